// ----- rtl/http_chunked_dechunker_unit_macros.svh -----
// Assertion macros shared by the dechunker RTL.
// No dependencies; taken in by `include in the files that check their logic.
`ifndef HTTP_CHUNKED_DECHUNKER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_DECHUNKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dechunker check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dechunker check failed");

`endif

// ----- rtl/hcd_pkg.sv -----
// Types, codes and constants of the chunked body decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int SIZE_W     = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VTAB  = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [SIZE_W-1:0] SIZE_MAX31 = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    PH_BLANK,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_SKIP,
    PH_LINE_LF,
    PH_PAYLOAD,
    PH_TRAIL_CR,
    PH_TRAIL_LF,
    PH_DONE,
    PH_FAIL
  } hcd_phase_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_LAST  = 2'd1,
    ST_ERROR = 2'd2
  } hcd_status_e;

  // One classified input byte.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       last;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       blank;
    logic       cr;
    logic       lf;
    logic       minus;
    logic       plus;
    logic       x_mark;
  } hcd_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    hcd_status_e status;
    logic [31:0] decoded_length;
  } hcd_result_t;

endpackage

`default_nettype wire

// ----- rtl/hcd_front.sv -----
// Front end: classifies each accepted body byte and queues it for the decoder.
// Depends on hcd_pkg.
`default_nettype none

module hcd_front import hcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  logic [7:0] body_byte_i,
  input  logic      buffer_end_i,
  output hcd_item_t item_o,
  output logic      empty_o,
  input  logic      pop_i
);

  hcd_item_t          cls;
  hcd_item_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;
  logic               is_dec, is_low, is_up;

  always_comb begin
    is_dec = (body_byte_i >= 8'h30) && (body_byte_i <= 8'h39);
    is_low = (body_byte_i >= 8'h61) && (body_byte_i <= 8'h66);
    is_up  = (body_byte_i >= 8'h41) && (body_byte_i <= 8'h46);
    cls.body_byte = body_byte_i;
    cls.last      = buffer_end_i;
    cls.hex_ok    = is_dec | is_low | is_up;
    cls.hex_val   = is_dec ? body_byte_i[3:0] : 4'(body_byte_i[3:0] + 4'd9);
    cls.blank     = (body_byte_i == CH_SPACE) || (body_byte_i == CH_TAB) ||
                    (body_byte_i == CH_VTAB) || (body_byte_i == CH_FF);
    cls.cr        = body_byte_i == CH_CR;
    cls.lf        = body_byte_i == CH_LF;
    cls.minus     = body_byte_i == CH_MINUS;
    cls.plus      = body_byte_i == CH_PLUS;
    cls.x_mark    = (body_byte_i == CH_LOW_X) || (body_byte_i == CH_UP_X);
  end

  assign full    = cnt_q == QCNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hcd_back.sv -----
// Back end: the decoding state machine with size, remaining and length counters.
// Depends on hcd_pkg and the assertion macros header.
`default_nettype none
`include "http_chunked_dechunker_unit_macros.svh"

module hcd_back import hcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hcd_item_t   item_i,
  input  logic        item_empty_i,
  output logic        item_pop_o,
  output hcd_result_t res_o,
  output logic        res_push_o,
  input  logic        res_full_i
);

  hcd_phase_e            phase_q, phase_d;
  logic [SIZE_W-1:0]     acc_q, acc_d, left_q, left_d, acc_shift, left_dec;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  take, last, acc_zero, acc_ovf, shift_zero, from_start;
  logic                  valid;
  hcd_status_e           status;

  function automatic hcd_phase_e end_phase(logic zero, logic fin, hcd_item_t it);
    if (zero) return PH_DONE;
    if (fin || it.lf) return PH_FAIL;
    if (it.cr) return PH_LINE_LF;
    return PH_SKIP;
  endfunction

  function automatic hcd_status_e end_status(logic zero, logic fin, hcd_item_t it);
    if (zero) return ST_LAST;
    if (fin || it.lf) return ST_ERROR;
    return ST_RUN;
  endfunction

  assign take       = ~item_empty_i & ~res_full_i;
  assign item_pop_o = take;
  assign res_push_o = take;
  assign last       = item_i.last;
  assign acc_zero   = acc_q == '0;
  assign acc_ovf    = acc_q > (SIZE_MAX31 >> 4);
  assign acc_shift  = {acc_q[SIZE_W-5:0], item_i.hex_val};
  assign shift_zero = acc_zero && (item_i.hex_val == 4'd0);
  assign from_start = (phase_q == PH_BLANK) || (phase_q == PH_SIGNED);
  assign left_dec   = (left_q == '0) ? '0 : SIZE_W'(left_q - 1'b1);
  assign cnt_inc    = (phase_q == PH_PAYLOAD) ? COUNT_BITS'(cnt_q + 1'b1) : cnt_q;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    left_d  = left_q;
    cnt_d   = cnt_inc;
    unique case (phase_q)
      PH_BLANK, PH_SIGNED, PH_ZERO, PH_DIGITS: begin
        priority if (phase_q == PH_BLANK && item_i.blank && !last) begin
          phase_d = PH_BLANK;
        end else if (phase_q == PH_BLANK && item_i.blank) begin
          phase_d = end_phase(acc_zero, 1'b1, item_i);
        end else if (phase_q == PH_BLANK && item_i.minus) begin
          phase_d = PH_FAIL;
        end else if (phase_q == PH_BLANK && item_i.plus && !last) begin
          phase_d = PH_SIGNED;
        end else if (phase_q == PH_ZERO && item_i.x_mark) begin
          phase_d = last ? end_phase(acc_zero, 1'b1, item_i) : PH_DIGITS;
        end else if (item_i.hex_ok) begin
          if (acc_ovf) begin
            phase_d = PH_FAIL;
          end else begin
            acc_d = acc_shift;
            if (last) begin
              phase_d = end_phase(shift_zero, 1'b1, item_i);
            end else if (from_start && item_i.hex_val == 4'd0) begin
              phase_d = PH_ZERO;
            end else begin
              phase_d = PH_DIGITS;
            end
          end
        end else begin
          phase_d = end_phase(acc_zero, last, item_i);
        end
      end
      PH_SKIP: begin
        if (last || item_i.lf) begin
          phase_d = PH_FAIL;
        end else if (item_i.cr) begin
          phase_d = PH_LINE_LF;
        end
      end
      PH_LINE_LF: begin
        if (last || !item_i.lf) begin
          phase_d = PH_FAIL;
        end else begin
          left_d  = acc_q;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_d = left_dec;
        if (last) begin
          phase_d = PH_FAIL;
        end else if (left_dec == '0) begin
          phase_d = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        phase_d = (last || !item_i.cr) ? PH_FAIL : PH_TRAIL_LF;
      end
      PH_TRAIL_LF: begin
        if (last || !item_i.lf) begin
          phase_d = PH_FAIL;
        end else begin
          phase_d = PH_BLANK;
          acc_d   = '0;
        end
      end
      PH_DONE, PH_FAIL: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = PH_FAIL;
      end
    endcase
    if (last) begin
      phase_d = PH_BLANK;
      acc_d   = '0;
      left_d  = '0;
      cnt_d   = '0;
    end
  end

  // Outputs.
  always_comb begin
    status = ST_RUN;
    valid  = 1'b0;
    unique case (phase_q)
      PH_BLANK, PH_SIGNED, PH_ZERO, PH_DIGITS: begin
        priority if (phase_q == PH_BLANK && item_i.blank && !last) begin
          status = ST_RUN;
        end else if (phase_q == PH_BLANK && item_i.blank) begin
          status = end_status(acc_zero, 1'b1, item_i);
        end else if (phase_q == PH_BLANK && item_i.minus) begin
          status = ST_ERROR;
        end else if (phase_q == PH_BLANK && item_i.plus && !last) begin
          status = ST_RUN;
        end else if (phase_q == PH_ZERO && item_i.x_mark) begin
          status = last ? end_status(acc_zero, 1'b1, item_i) : ST_RUN;
        end else if (item_i.hex_ok) begin
          if (acc_ovf) begin
            status = ST_ERROR;
          end else if (last) begin
            status = end_status(shift_zero, 1'b1, item_i);
          end
        end else begin
          status = end_status(acc_zero, last, item_i);
        end
      end
      PH_SKIP: begin
        status = (last || item_i.lf) ? ST_ERROR : ST_RUN;
      end
      PH_LINE_LF: begin
        status = (last || !item_i.lf) ? ST_ERROR : ST_RUN;
      end
      PH_PAYLOAD: begin
        valid  = 1'b1;
        status = last ? ST_ERROR : ST_RUN;
      end
      PH_TRAIL_CR: begin
        status = (last || !item_i.cr) ? ST_ERROR : ST_RUN;
      end
      PH_TRAIL_LF: begin
        status = (last || !item_i.lf) ? ST_ERROR : ST_RUN;
      end
      PH_DONE, PH_FAIL: begin
        status = ST_RUN;
      end
      default: begin
        status = ST_ERROR;
      end
    endcase
  end

  always_comb begin
    res_o.payload_byte   = valid ? item_i.body_byte : 8'd0;
    res_o.payload_valid  = valid;
    res_o.status         = status;
    res_o.decoded_length = 32'(cnt_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BLANK;
      acc_q   <= '0;
      left_q  <= '0;
      cnt_q   <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

  `HCD_ASSERT_NOW(a_valid_in_payload, clk_i, rst_ni, take && res_o.payload_valid, phase_q == PH_PAYLOAD)
  `HCD_ASSERT_NOW(a_size_in_range, clk_i, rst_ni, 1'b1, acc_q <= SIZE_MAX31)
  `HCD_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, take && last, phase_q == PH_BLANK && cnt_q == '0)
  `HCD_ASSERT_NEXT(a_halt_holds, clk_i, rst_ni, take && !last && (phase_q == PH_DONE || phase_q == PH_FAIL), phase_q == $past(phase_q))

endmodule

`default_nettype wire

// ----- rtl/hcd_out_queue.sv -----
// Result queue that holds finished result items until they are taken.
// Depends on hcd_pkg.
`default_nettype none

module hcd_out_queue import hcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hcd_result_t res_i,
  input  logic        push_i,
  output logic        full_o,
  output hcd_result_t res_o,
  output logic        empty,
  input  logic        pop
);

  hcd_result_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign empty   = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop & ~empty;
  assign res_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/http_chunked_dechunker_unit.sv -----
// Top level of the chunked HTTP body decoder.
// Depends on hcd_pkg, hcd_front, hcd_back and hcd_out_queue.
//
// Takes one body byte per transfer and returns exactly one result per byte:
// the payload byte with its valid flag, a status (running, last chunk, error)
// and the payload length counted so far in the current buffer. A byte can be
// accepted in every clock cycle unless the input queue is full; the decoding
// state machine retires one byte per cycle unless the input queue is empty or
// the result queue is full. Two-entry queues on the input and the result side
// let each side stall on its own. A byte marked as buffer end returns the
// decoder to its reset state once its result is produced.
`default_nettype none

module http_chunked_dechunker_unit import hcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  body_byte_i,
  input  logic        buffer_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] decoded_length_o
);

  hcd_item_t   item;
  hcd_result_t res_new, res_out;
  logic        item_empty, item_pop, res_push, res_full;

  hcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .body_byte_i (body_byte_i),
    .buffer_end_i(buffer_end_i),
    .item_o      (item),
    .empty_o     (item_empty),
    .pop_i       (item_pop)
  );

  hcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_o       (res_new),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  hcd_out_queue u_out_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .res_i (res_new),
    .push_i(res_push),
    .full_o(res_full),
    .res_o (res_out),
    .empty (empty),
    .pop   (pop)
  );

  assign payload_byte_o   = res_out.payload_byte;
  assign payload_valid_o  = res_out.payload_valid;
  assign status_o         = res_out.status;
  assign decoded_length_o = res_out.decoded_length;

endmodule

`default_nettype wire

// ----- sim/hcd_decode_checker.sv -----
// Result checker for the chunked body decoder: watches the byte and result transfers,
// decodes every accepted byte on its own and compares each popped result with it.
// Depends on hcd_pkg for the phase and status codes, the widths and the result layout.
module hcd_decode_checker import hcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  body_byte_i,
  input  logic        buffer_end_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        payload_valid_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] decoded_length_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          live_o,
  output int          checked_o,
  output int          payload_o,
  output int          last_o,
  output int          error_o
);

  hcd_phase_e            dec_phase;
  logic [SIZE_W-1:0]     chunk_size;
  logic [SIZE_W-1:0]     remaining;
  logic [COUNT_BITS-1:0] byte_total;
  hcd_result_t           pending_results[$];
  int                    mismatches;
  int                    live_bytes;
  int                    checked;
  int                    payload_bytes;
  int                    last_reports;
  int                    error_reports;

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FF;
  endfunction

  function automatic void clear_decoder();
    dec_phase  = PH_BLANK;
    chunk_size = '0;
    remaining  = '0;
    byte_total = '0;
  endfunction

  function automatic hcd_status_e abort();
    dec_phase = PH_FAIL;
    return ST_ERROR;
  endfunction

  function automatic hcd_status_e add_digit(input logic [3:0] d);
    if (chunk_size > (SIZE_MAX31 >> 4)) return abort();
    chunk_size = {chunk_size[SIZE_W-5:0], d};
    dec_phase  = PH_DIGITS;
    return ST_RUN;
  endfunction

  // The size number has ended on byte b.
  function automatic hcd_status_e close_size(input logic [7:0] b, input logic last);
    if (chunk_size == '0) begin
      dec_phase = PH_DONE;
      return ST_LAST;
    end
    if (last || b == CH_LF) return abort();
    dec_phase = (b == CH_CR) ? PH_LINE_LF : PH_SKIP;
    return ST_RUN;
  endfunction

  function automatic hcd_result_t decode_byte(input logic [7:0] b, input logic last);
    hcd_result_t res;
    hcd_status_e st;
    logic        vld;
    int          d;
    st  = ST_RUN;
    vld = 1'b0;
    d   = hex_digit(b);
    case (dec_phase)
      PH_BLANK, PH_SIGNED: begin
        if (dec_phase == PH_BLANK && is_blank(b)) begin
          if (last) st = close_size(b, 1'b1);
        end else if (dec_phase == PH_BLANK && b == CH_MINUS) begin
          st = abort();
        end else if (dec_phase == PH_BLANK && b == CH_PLUS && !last) begin
          dec_phase = PH_SIGNED;
        end else if (d >= 0) begin
          st = add_digit(d[3:0]);
          if (st == ST_RUN && d == 0) dec_phase = PH_ZERO;
          if (st == ST_RUN && last) st = close_size(b, 1'b1);
        end else begin
          st = close_size(b, last);
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (dec_phase == PH_ZERO && (b == CH_LOW_X || b == CH_UP_X)) begin
          dec_phase = PH_DIGITS;
          if (last) st = close_size(b, 1'b1);
        end else if (d >= 0) begin
          st = add_digit(d[3:0]);
          if (st == ST_RUN && last) st = close_size(b, 1'b1);
        end else begin
          st = close_size(b, last);
        end
      end
      PH_SKIP: begin
        if (last || b == CH_LF) st = abort();
        else if (b == CH_CR) dec_phase = PH_LINE_LF;
      end
      PH_LINE_LF: begin
        if (last || b != CH_LF) begin
          st = abort();
        end else begin
          remaining = chunk_size;
          dec_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        vld        = 1'b1;
        byte_total = byte_total + 1'b1;
        if (remaining != '0) remaining = remaining - 1'b1;
        if (last) st = abort();
        else if (remaining == '0) dec_phase = PH_TRAIL_CR;
      end
      PH_TRAIL_CR: begin
        if (last || b != CH_CR) st = abort();
        else dec_phase = PH_TRAIL_LF;
      end
      PH_TRAIL_LF: begin
        if (last || b != CH_LF) begin
          st = abort();
        end else begin
          dec_phase  = PH_BLANK;
          chunk_size = '0;
        end
      end
      default: begin
      end
    endcase
    res.payload_byte   = vld ? b : 8'h00;
    res.payload_valid  = vld;
    res.status         = st;
    res.decoded_length = byte_total[31:0];
    if (last) clear_decoder();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hcd_result_t want;
    if (!rst_ni) begin
      clear_decoder();
      pending_results.delete();
      mismatches    = 0;
      live_bytes    = 0;
      checked       = 0;
      payload_bytes = 0;
      last_reports  = 0;
      error_reports = 0;
    end else begin
      if (pop_i && !empty_i) begin
        checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: byte %02h valid %0b status %0d length %0d",
                     payload_byte_i, payload_valid_i, status_i, decoded_length_i);
        end else begin
          want = pending_results.pop_front();
          if (payload_byte_i !== want.payload_byte || payload_valid_i !== want.payload_valid ||
              status_i !== want.status || decoded_length_i !== want.decoded_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected byte %02h valid %0b status %0d length %0d, got %02h %0b %0d %0d",
                       want.payload_byte, want.payload_valid, want.status,
                       want.decoded_length, payload_byte_i, payload_valid_i, status_i,
                       decoded_length_i);
          end
        end
      end
      if (push_i && !full_i) begin
        live_bytes++;
        want = decode_byte(body_byte_i, buffer_end_i);
        pending_results.insert(pending_results.size(), want);
        if (want.payload_valid) payload_bytes++;
        if (want.status == ST_LAST) last_reports++;
        if (want.status == ST_ERROR) error_reports++;
      end
    end
    pending_o    <= pending_results.size();
    fail_count_o <= mismatches;
    live_o       <= live_bytes;
    checked_o    <= checked;
    payload_o    <= payload_bytes;
    last_o       <= last_reports;
    error_o      <= error_reports;
  end

endmodule

// ----- sim/tb_http_chunked_dechunker_unit.sv -----
// Top of the chunked body decoder testbench: clock, reset, byte and pop stimulus, verdict.
// Depends on hcd_pkg, the decoder top level and hcd_decode_checker.
module tb_http_chunked_dechunker_unit;
  import hcd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int ITEM_GOAL = 1850;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  body_byte_i  = 8'h00;
  logic        buffer_end_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [7:0]  payload_byte_o;
  logic        payload_valid_o;
  logic [1:0]  status_o;
  logic [31:0] decoded_length_o;

  int send_idle_pct = 18;
  int pop_idle_pct  = 85;
  int pending;
  int failures;
  int live_bytes;
  int checked;
  int payload_bytes;
  int last_reports;
  int error_reports;

  always #4 clk_i = ~clk_i;

  http_chunked_dechunker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .body_byte_i     (body_byte_i),
    .buffer_end_i    (buffer_end_i),
    .empty           (empty),
    .pop             (pop),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .status_o        (status_o),
    .decoded_length_o(decoded_length_o)
  );

  hcd_decode_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .body_byte_i     (body_byte_i),
    .buffer_end_i    (buffer_end_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .payload_byte_i  (payload_byte_o),
    .payload_valid_i (payload_valid_o),
    .status_i        (status_o),
    .decoded_length_i(decoded_length_o),
    .pending_o       (pending),
    .fail_count_o    (failures),
    .live_o          (live_bytes),
    .checked_o       (checked),
    .payload_o       (payload_bytes),
    .last_o          (last_reports),
    .error_o         (error_reports)
  );

  always @(posedge clk_i) pop <= ($urandom_range(0, 99) >= pop_idle_pct);

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    body_byte_i  <= b;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_buffer(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    byte_q_t     body;
    int unsigned size;
    int          n_chunks;
    string       digits;
    logic [7:0]  ch;
    bit          cut;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_buffer('{CH_TAB, CH_PLUS, "0", CH_UP_X, "2", CH_CR, CH_LF, 8'h00, 8'hFF,
                  CH_CR, CH_LF, "0"});
    send_buffer('{CH_MINUS});
    send_buffer('{"8", "0", "0", "0", "0", "0", "0", "0"});
    send_buffer('{"1", CH_LF, "z"});
    send_buffer('{"1", CH_CR, "a"});
    send_buffer('{CH_VTAB, CH_FF, CH_CR, CH_LF});

    for (int mode = 0; mode < 3; mode++) begin
      wait_drained();
      case (mode)
        0: begin
          send_idle_pct = 18;
          pop_idle_pct  = 85;
        end
        1: begin
          send_idle_pct = 85;
          pop_idle_pct  = 18;
        end
        default: begin
          send_idle_pct = 0;
          pop_idle_pct  = 0;
        end
      endcase
      while (live_bytes < (mode + 1) * ITEM_GOAL / 3) begin
        body.delete();
        cut      = 1'b0;
        n_chunks = $urandom_range(0, 3);
        for (int c = 0; c <= n_chunks && !cut; c++) begin
          size = (c == n_chunks) ? 0 : $urandom_range(1, 12);
          if ($urandom_range(0, 19) == 0)
            size = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : $urandom;
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
              0: body.insert(body.size(), CH_SPACE);
              1: body.insert(body.size(), CH_TAB);
              2: body.insert(body.size(), CH_VTAB);
              default: body.insert(body.size(), CH_FF);
            endcase
          end
          if ($urandom_range(0, 3) == 0) body.insert(body.size(), CH_PLUS);
          if ($urandom_range(0, 3) == 0) begin
            body.insert(body.size(), "0");
            body.insert(body.size(), $urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
          end
          if (size != 0 || $urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(0, 2)) body.insert(body.size(), "0");
            digits = $sformatf("%0h", size);
            foreach (digits[i]) begin
              ch = digits[i];
              if (ch >= "a" && $urandom_range(0, 1)) ch = ch - 8'h20;
              body.insert(body.size(), ch);
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            body.insert(body.size(), ";");
            repeat ($urandom_range(0, 4))
              body.insert(body.size(), 8'($urandom_range(8'h20, 8'h7E)));
          end
          body.insert(body.size(), CH_CR);
          body.insert(body.size(), CH_LF);
          if (size > 64) begin
            // A size this large cannot be filled; the buffer ends inside the chunk.
            repeat ($urandom_range(0, 4)) body.insert(body.size(), 8'($urandom));
            cut = 1'b1;
          end else if (size != 0) begin
            repeat (size) body.insert(body.size(), 8'($urandom));
            body.insert(body.size(), CH_CR);
            body.insert(body.size(), CH_LF);
          end else if ($urandom_range(0, 1)) begin
            body.insert(body.size(), CH_CR);
            body.insert(body.size(), CH_LF);
          end
        end
        case ($urandom_range(0, 9))
          0: body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
          1: body = body[0:$urandom_range(0, body.size() - 1)];
          2: begin
            body.delete();
            repeat ($urandom_range(1, 8)) body.insert(body.size(), 8'($urandom));
          end
          default: begin
          end
        endcase
        send_buffer(body);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results for %0d input bytes in three idle patterns.",
             checked, live_bytes);
    $display("They held %0d payload bytes, %0d last-chunk and %0d error reports.",
             payload_bytes, last_reports, error_reports);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("FAIL");
    $finish;
  end

endmodule
